### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion macros for the frame parser
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

### src/lcfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcfp_pkg
// types and constants of the length / checksum frame parser
// ----------------------------------------------------------------------------
package lcfp_pkg;

    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 32;
    localparam int LEN_W       = 3;
    localparam int FILL_W      = 3;
    localparam int NUM_PAYLOAD = 4;
    localparam int ADDR_W      = 2;
    localparam int DATA_W      = 32;

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hAA;
    localparam logic [ADDR_W-1:0] REG_HEADER   = 2'd0;

    typedef logic [BYTE_W-1:0] byte_t;

    // parser phase
    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2,
        PH_SUM  = 2'd3
    } phase_t;

    // event code of one result item
    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_GOOD    = 2'd1,
        EV_LEN_ERR = 2'd2,
        EV_SUM_ERR = 2'd3
    } event_t;

    typedef struct packed {
        event_t                         event_res;
        logic [COUNT_W-1:0]             good_frames;
        logic [COUNT_W-1:0]             bad_frames;
        logic [LEN_W-1:0]               payload_count;
        byte_t                          command;
        logic [NUM_PAYLOAD-1:0][BYTE_W-1:0] payload;
    } result_t;

endpackage

### src/lcfp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcfp_parser
// frame state machine, body store, running checksum and frame counters;
// builds the result of the byte presented this cycle
// ----------------------------------------------------------------------------
module lcfp_parser #(
    parameter int MAX_PAYLOAD = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  lcfp_pkg::byte_t   header_byte,
    input  logic              in_fire,
    input  lcfp_pkg::byte_t   rx_byte,
    output lcfp_pkg::result_t res
);

    localparam int BODY_DEPTH = MAX_PAYLOAD + 1;
    localparam int IDX_W      = $clog2(BODY_DEPTH);

    lcfp_pkg::phase_t                phase_reg, phase_next;
    logic [lcfp_pkg::LEN_W-1:0]      frame_len_reg, frame_len_next;
    logic [lcfp_pkg::FILL_W-1:0]     fill_reg, fill_next, fill_inc;
    lcfp_pkg::byte_t                 sum_reg, sum_next;
    logic [lcfp_pkg::COUNT_W-1:0]    ok_reg, ok_next, err_reg, err_next;
    lcfp_pkg::byte_t                 body_store [BODY_DEPTH];
    logic                            body_we;
    logic                            len_too_big;
    lcfp_pkg::event_t                event_code;
    logic [lcfp_pkg::NUM_PAYLOAD-1:0][lcfp_pkg::BYTE_W-1:0] pay;

    assign len_too_big = rx_byte > lcfp_pkg::BYTE_W'(MAX_PAYLOAD);
    assign fill_inc    = fill_reg + 3'd1;

    // next state of the parser
    always_comb begin
        phase_next     = phase_reg;
        frame_len_next = frame_len_reg;
        fill_next      = fill_reg;
        sum_next       = sum_reg;
        body_we        = 1'b0;
        case (phase_reg)
            lcfp_pkg::PH_HUNT: begin
                if (rx_byte == header_byte) begin
                    phase_next = lcfp_pkg::PH_LEN;
                end
            end
            lcfp_pkg::PH_LEN: begin
                if (len_too_big) begin
                    phase_next = lcfp_pkg::PH_HUNT;
                    fill_next  = '0;
                    sum_next   = '0;
                end else begin
                    frame_len_next = rx_byte[lcfp_pkg::LEN_W-1:0];
                    sum_next       = rx_byte;
                    fill_next      = '0;
                    phase_next     = lcfp_pkg::PH_BODY;
                end
            end
            lcfp_pkg::PH_BODY: begin
                body_we   = fill_reg < lcfp_pkg::FILL_W'(BODY_DEPTH);
                fill_next = fill_inc;
                sum_next  = sum_reg + rx_byte;
                if ({1'b0, fill_inc} >= ({1'b0, frame_len_reg} + 4'd1)) begin
                    phase_next = lcfp_pkg::PH_SUM;
                end
            end
            lcfp_pkg::PH_SUM: begin
                fill_next  = '0;
                sum_next   = '0;
                phase_next = (rx_byte == header_byte) ? lcfp_pkg::PH_LEN
                                                      : lcfp_pkg::PH_HUNT;
            end
            default: begin
                phase_next = lcfp_pkg::PH_HUNT;
            end
        endcase
    end

    // event of this byte
    always_comb begin
        case (phase_reg)
            lcfp_pkg::PH_LEN: begin
                event_code = len_too_big ? lcfp_pkg::EV_LEN_ERR : lcfp_pkg::EV_NONE;
            end
            lcfp_pkg::PH_SUM: begin
                event_code = (rx_byte == sum_reg) ? lcfp_pkg::EV_GOOD
                                                  : lcfp_pkg::EV_SUM_ERR;
            end
            default: begin
                event_code = lcfp_pkg::EV_NONE;
            end
        endcase
    end

    assign ok_next  = ok_reg + lcfp_pkg::COUNT_W'(event_code == lcfp_pkg::EV_GOOD);
    assign err_next = err_reg + lcfp_pkg::COUNT_W'((event_code == lcfp_pkg::EV_LEN_ERR) ||
                                                   (event_code == lcfp_pkg::EV_SUM_ERR));

    // payload bytes present in the stored frame
    for (genvar gi = 0; gi < lcfp_pkg::NUM_PAYLOAD; gi++) begin : g_pay
        if (gi + 1 < BODY_DEPTH) begin : g_used
            assign pay[gi] = (lcfp_pkg::LEN_W'(gi) < frame_len_reg) ? body_store[gi + 1]
                                                                    : '0;
        end else begin : g_unused
            assign pay[gi] = '0;
        end
    end

    // result item
    always_comb begin
        res               = '0;
        res.event_res     = event_code;
        res.good_frames   = ok_next;
        res.bad_frames    = err_next;
        if (event_code == lcfp_pkg::EV_GOOD) begin
            res.payload_count = frame_len_reg;
            res.command       = body_store[0];
            res.payload       = pay;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= lcfp_pkg::PH_HUNT;
            frame_len_reg <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            ok_reg        <= '0;
            err_reg       <= '0;
        end else if (in_fire) begin
            phase_reg     <= phase_next;
            frame_len_reg <= frame_len_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            ok_reg        <= ok_next;
            err_reg       <= err_next;
        end
    end

    // body store, command then payload
    always_ff @(posedge aclk) begin
        if (in_fire && body_we) begin
            body_store[fill_reg[IDX_W-1:0]] <= rx_byte;
        end
    end

endmodule

### src/lcfp_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcfp_out_stage
// result register between the parser and the output channel
// ----------------------------------------------------------------------------
module lcfp_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  lcfp_pkg::result_t in_res,
    output logic              out_valid,
    input  logic              out_ready,
    output lcfp_pkg::result_t out_res
);

    logic              valid_reg, valid_next;
    lcfp_pkg::result_t data_reg;

    // free when empty or being drained this cycle
    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload holds until the next item is loaded
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= in_res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = data_reg;

endmodule

### src/length_checksum_frame_parser_unit.sv
// the result item of an accepted byte is registered and shown on the m_ side in the following cycle
// throughput: one byte per cycle while m_ready holds, set by the single result register stage
// s_ready is high whenever the result register is empty or being taken
// reset (aresetn low, synchronous) returns to header hunting, clears both
// frame counters and reloads header_byte with 0xAA
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// length_checksum_frame_parser_unit
// byte stream frame parser: header, length, command and payload, checksum
// ----------------------------------------------------------------------------
module length_checksum_frame_parser_unit #(
    parameter int MAX_PAYLOAD = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lcfp_pkg::ADDR_W-1:0]   paddr,
    input  logic [lcfp_pkg::DATA_W-1:0]   pwdata,
    output logic [lcfp_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    // input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_rx_byte,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_event_res,
    output logic [31:0]                   m_good_frames,
    output logic [31:0]                   m_bad_frames,
    output logic [2:0]                    m_payload_count,
    output logic [7:0]                    m_command,
    output logic [7:0]                    m_payload_0,
    output logic [7:0]                    m_payload_1,
    output logic [7:0]                    m_payload_2,
    output logic [7:0]                    m_payload_3
);

    lcfp_pkg::byte_t   header_reg;
    logic              cfg_we;
    logic              in_fire;
    lcfp_pkg::result_t parse_res;
    lcfp_pkg::result_t out_res;
    logic              out_good;
    logic              out_quiet;

    // configuration register
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr == lcfp_pkg::REG_HEADER);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg <= lcfp_pkg::HEADER_RESET;
        end else if (cfg_we) begin
            header_reg <= pwdata[lcfp_pkg::BYTE_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == lcfp_pkg::REG_HEADER) begin
            prdata = lcfp_pkg::DATA_W'(header_reg);
        end
    end

    assign in_fire = s_valid && s_ready;

    lcfp_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .header_byte (header_reg),
        .in_fire     (in_fire),
        .rx_byte     (s_rx_byte),
        .res         (parse_res)
    );

    lcfp_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_res    (parse_res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (out_res)
    );

    // unpack the result item
    assign m_event_res     = out_res.event_res;
    assign m_good_frames   = out_res.good_frames;
    assign m_bad_frames    = out_res.bad_frames;
    assign m_payload_count = out_res.payload_count;
    assign m_command       = out_res.command;
    assign m_payload_0     = out_res.payload[0];
    assign m_payload_1     = out_res.payload[1];
    assign m_payload_2     = out_res.payload[2];
    assign m_payload_3     = out_res.payload[3];

    // checks
    assign out_good  = m_valid && (m_event_res == lcfp_pkg::EV_GOOD);
    assign out_quiet = (m_payload_count == 3'd0) && (m_command == 8'd0);

    `ASSERT_NEXT(a_accept_fills, aclk, aresetn, in_fire, m_valid)
    `ASSERT_SAME(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready)
    `ASSERT_SAME(a_good_len, aclk, aresetn, out_good, m_payload_count <= 3'(MAX_PAYLOAD))
    `ASSERT_SAME(a_quiet_fields, aclk, aresetn, m_valid && !out_good, out_quiet)

endmodule
